// File: sv/quaternion_orientation_rotator_assert.svh
// assertion macros for the orientation rotator
`ifndef QUATERNION_ORIENTATION_ROTATOR_ASSERT_SVH
`define QUATERNION_ORIENTATION_ROTATOR_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define QOR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define QOR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/qor_pkg.sv
// ------------------------------------------------------------------
// qor_pkg
// types, constants and tables shared by the orientation rotator
// ------------------------------------------------------------------
`timescale 1ns / 1ps

package qor_pkg;

    localparam int CordicSteps = 16;
    localparam int FracBits    = 14;
    localparam int AccW        = 36;

    localparam logic signed [35:0] Q30Gain    = 36'sd652032874;
    localparam logic signed [35:0] Q30HalfPi  = 36'sd1686629713;
    localparam logic signed [35:0] Q30Pi      = 36'sd3373259426;
    localparam logic signed [35:0] Q30TwoPi   = 36'sd6746518852;

    typedef logic signed [15:0] comp_t;

    typedef struct packed {
        comp_t w;
        comp_t x;
        comp_t y;
        comp_t z;
    } quat_t;

    function automatic logic signed [35:0] atan_entry(input logic [4:0] i);
        logic signed [35:0] v;
        unique case (i)
            5'd0:  v = 36'sd843314856;
            5'd1:  v = 36'sd497837829;
            5'd2:  v = 36'sd263043836;
            5'd3:  v = 36'sd133525158;
            5'd4:  v = 36'sd67021686;
            5'd5:  v = 36'sd33543515;
            5'd6:  v = 36'sd16775850;
            5'd7:  v = 36'sd8388437;
            5'd8:  v = 36'sd4194282;
            5'd9:  v = 36'sd2097149;
            5'd10: v = 36'sd1048575;
            5'd11: v = 36'sd524287;
            5'd12: v = 36'sd262143;
            5'd13: v = 36'sd131071;
            5'd14: v = 36'sd65535;
            5'd15: v = 36'sd32767;
            5'd16: v = 36'sd16383;
            5'd17: v = 36'sd8191;
            5'd18: v = 36'sd4095;
            5'd19: v = 36'sd2047;
            5'd20: v = 36'sd1023;
            5'd21: v = 36'sd511;
            5'd22: v = 36'sd255;
            5'd23: v = 36'sd127;
            default: v = 36'sd0;
        endcase
        return v;
    endfunction

endpackage

// File: sv/qor_cordic.sv
// ------------------------------------------------------------------
// qor_cordic
// rotation-mode cordic, one micro-rotation per cycle, q30
// ------------------------------------------------------------------
`timescale 1ns / 1ps

module qor_cordic
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [35:0]  ang,
    output logic                done,
    output logic signed [35:0]  cos_q30,
    output logic signed [35:0]  sin_q30
);
    import qor_pkg::*;

    logic               busy_reg, busy_next;
    logic [4:0]         step_reg, step_next;
    logic               neg_reg, neg_next;
    logic signed [35:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic signed [35:0] zr, dx, dy;
    logic               done_reg, done_next;

    // angle reduction: |ang| < 2^30 * 4, so modulo needs at most one step
    always_comb
    begin
        zr = ang;
        if (zr > Q30TwoPi)
            zr = zr - Q30TwoPi;
        else if (zr < -Q30TwoPi)
            zr = zr + Q30TwoPi;
        if (zr > Q30Pi)
            zr = zr - Q30TwoPi;
        if (zr < -Q30Pi)
            zr = zr + Q30TwoPi;
    end

    assign dx = y_reg >>> step_reg;
    assign dy = x_reg >>> step_reg;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        neg_next  = neg_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            x_next    = Q30Gain;
            y_next    = '0;
            neg_next  = 1'b0;
            z_next    = zr;
            if (zr > Q30HalfPi)
            begin
                z_next   = zr - Q30Pi;
                neg_next = 1'b1;
            end
            else if (zr < -Q30HalfPi)
            begin
                z_next   = zr + Q30Pi;
                neg_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (z_reg >= 0)
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - atan_entry(step_reg);
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + atan_entry(step_reg);
            end
            step_next = step_reg + 5'd1;
            if (step_reg == 5'(CordicSteps - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
    end

    assign done    = done_reg;
    assign cos_q30 = neg_reg ? -x_reg : x_reg;
    assign sin_q30 = neg_reg ? -y_reg : y_reg;

endmodule

// File: sv/qor_isqrt.sv
// ------------------------------------------------------------------
// qor_isqrt
// bitwise integer square root, one result bit per cycle
// ------------------------------------------------------------------
`timescale 1ns / 1ps

module qor_isqrt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [49:0] val,
    output logic        done,
    output logic [24:0] root
);
    import qor_pkg::*;

    logic        busy_reg, busy_next, done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [49:0] rem_reg, rem_next, res_reg, res_next, bit_reg, bit_next;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = val;
            res_next  = '0;
            bit_next  = 50'd1 << 48;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= res_reg + bit_reg)
            begin
                rem_next = rem_reg - (res_reg + bit_reg);
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
                res_next = res_reg >> 1;
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd24)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[24:0];

endmodule

// File: sv/qor_divider.sv
// ------------------------------------------------------------------
// qor_divider
// restoring unsigned divider, one quotient bit per cycle
// ------------------------------------------------------------------
`timescale 1ns / 1ps

module qor_divider
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [40:0] den,
    output logic        done,
    output logic [63:0] quot,
    output logic [40:0] rem
);
    import qor_pkg::*;

    logic        busy_reg, busy_next, done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] q_reg, q_next;
    logic [41:0] r_reg, r_next, trial;
    logic [40:0] d_reg, d_next;

    assign trial = {r_reg[40:0], q_reg[63]} - {1'b0, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = num;
            r_next    = '0;
            d_next    = den;
        end
        else if (busy_reg)
        begin
            if (!trial[41])
            begin
                r_next = trial;
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[40:0], q_reg[63]};
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg[40:0];

endmodule

// File: sv/quaternion_orientation_rotator.sv
// a load raises out_valid in the cycle after acceptance; a rotate forms the squared
// length, then runs the square root with the cordic alongside, then each vector part
// through one shared bit-serial divider, then sixteen hamilton terms on one shared
// 16x18 multiplier, and with a zero axis stops after the squared length.
// one word in flight; in_stall high while busy or result waiting, next word taken
// the cycle after the result leaves. reset: orientation identity, no result pending.
`timescale 1ns / 1ps

module quaternion_orientation_rotator
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    kind,
    input  logic signed [15:0]      axis_x,
    input  logic signed [15:0]      axis_y,
    input  logic signed [15:0]      axis_z,
    input  logic signed [15:0]      angle,
    input  logic signed [15:0]      load_w,
    input  logic signed [15:0]      load_x,
    input  logic signed [15:0]      load_y,
    input  logic signed [15:0]      load_z,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [15:0]      out_w,
    output logic signed [15:0]      out_x,
    output logic signed [15:0]      out_y,
    output logic signed [15:0]      out_z,
    output logic                    zero_axis,
    output logic                    saturated
);
    import qor_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MAG  = 4'd1;
    localparam logic [3:0] S_CORD = 4'd2;
    localparam logic [3:0] S_SQRT = 4'd3;
    localparam logic [3:0] S_SINM = 4'd4;
    localparam logic [3:0] S_DIVS = 4'd5;
    localparam logic [3:0] S_DIVW = 4'd6;
    localparam logic [3:0] S_MUL  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0]         state_reg, state_next;
    quat_t              q_reg, q_next;
    quat_t              r_reg, r_next;
    quat_t              n_reg, n_next;
    logic signed [15:0] ax_reg, ay_reg, az_reg, ang_reg;
    logic               ovalid_reg, ovalid_next;
    logic               zero_reg, zero_next, sat_reg, sat_next;
    logic [33:0]        m2_reg, m2_next;
    logic [1:0]         idx_reg, idx_next;
    logic [3:0]         mcnt_reg, mcnt_next;
    logic signed [35:0] s30_reg, s30_next;
    logic [24:0]        mag_reg, mag_next;
    logic signed [AccW-1:0] acc_reg, acc_next;
    logic signed [35:0] prod_reg;
    logic               prod_en_reg;
    logic               prod_neg_reg;
    logic [1:0]         pidx_reg;
    logic               plast_reg;

    logic               in_acc;
    logic               cord_start, cord_done, sq_start, sq_done, dv_start, dv_done;
    logic signed [35:0] cos30, sin30;
    logic [24:0]        root;
    logic [63:0]        dv_num, quot;
    logic [40:0]        dv_den, drem;
    logic signed [15:0] ax_sel, mul_a;
    logic signed [17:0] mul_b;
    logic               mul_neg;
    logic [1:0]         ri;
    logic signed [31:0] sq_a;
    logic signed [63:0] num_s;
    logic [63:0]        num_abs;
    logic signed [16:0] rq;
    logic signed [AccW-1:0] acc_sum;
    logic signed [AccW-1:0] sh;
    logic signed [16:0] cosr;
    logic signed [36:0] cos_abs;

    assign in_acc   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE) || ovalid_reg;

    qor_cordic u_cordic (.clk, .rst_n, .start(cord_start), .ang({{4{ang_reg[15]}}, ang_reg,
        16'd0}), .done(cord_done), .cos_q30(cos30), .sin_q30(sin30));
    qor_isqrt u_isqrt (.clk, .rst_n, .start(sq_start), .val({m2_reg, 16'd0}),
        .done(sq_done), .root);
    qor_divider u_div (.clk, .rst_n, .start(dv_start), .num(dv_num), .den(dv_den),
        .done(dv_done), .quot, .rem(drem));

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    ax_sel = ax_reg;
            2'd1:    ax_sel = ay_reg;
            default: ax_sel = az_reg;
        endcase
    end

    // numerator axis * s30 * 256; s30 below 2^31 fits with axis in 64 bits
    assign num_s   = 64'(ax_sel) * 64'(s30_reg) * 64'sd256;
    assign num_abs = num_s[63] ? 64'(-num_s) : 64'(num_s);
    assign dv_num  = num_abs;
    assign dv_den  = {mag_reg, 16'd0};
    assign rq      = 17'((drem >= {1'b0, dv_den[40:1]} + 41'(dv_den[0])) ?
                     quot + 64'd1 : quot);

    assign cos_abs = cos30[35] ? -37'(cos30) : 37'(cos30);
    assign cosr    = cos30[35] ? -17'((cos_abs + 37'd32768) >>> 16)
                               : 17'((cos_abs + 37'd32768) >>> 16);

    // hamilton term table: mcnt = 4 * out + term
    always_comb
    begin
        mul_neg = 1'b0;
        unique case (mcnt_reg)
            4'd0:  begin mul_a = q_reg.w; ri = 2'd0; end
            4'd1:  begin mul_a = q_reg.x; ri = 2'd1; mul_neg = 1'b1; end
            4'd2:  begin mul_a = q_reg.y; ri = 2'd2; mul_neg = 1'b1; end
            4'd3:  begin mul_a = q_reg.z; ri = 2'd3; mul_neg = 1'b1; end
            4'd4:  begin mul_a = q_reg.w; ri = 2'd1; end
            4'd5:  begin mul_a = q_reg.x; ri = 2'd0; end
            4'd6:  begin mul_a = q_reg.y; ri = 2'd3; end
            4'd7:  begin mul_a = q_reg.z; ri = 2'd2; mul_neg = 1'b1; end
            4'd8:  begin mul_a = q_reg.w; ri = 2'd2; end
            4'd9:  begin mul_a = q_reg.y; ri = 2'd0; end
            4'd10: begin mul_a = q_reg.z; ri = 2'd1; end
            4'd11: begin mul_a = q_reg.x; ri = 2'd3; mul_neg = 1'b1; end
            4'd12: begin mul_a = q_reg.w; ri = 2'd3; end
            4'd13: begin mul_a = q_reg.z; ri = 2'd0; end
            4'd14: begin mul_a = q_reg.x; ri = 2'd2; end
            default: begin mul_a = q_reg.y; ri = 2'd1; mul_neg = 1'b1; end
        endcase
        unique case (ri)
            2'd0:    mul_b = 18'(r_reg.w);
            2'd1:    mul_b = 18'(r_reg.x);
            2'd2:    mul_b = 18'(r_reg.y);
            default: mul_b = 18'(r_reg.z);
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= 36'(mul_a) * 36'(mul_b);
        prod_neg_reg <= mul_neg;
        pidx_reg     <= mcnt_reg[3:2];
        plast_reg    <= (mcnt_reg[1:0] == 2'd3);
    end

    assign acc_sum = acc_reg + (prod_neg_reg ? -AccW'(prod_reg) : AccW'(prod_reg));
    assign sh      = (acc_sum + AccW'(1 << (FracBits - 1))) >>> FracBits;

    always_comb
    begin
        state_next  = state_reg;
        q_next      = q_reg;
        r_next      = r_reg;
        n_next      = n_reg;
        ovalid_next = ovalid_reg && out_stall;
        zero_next   = zero_reg;
        sat_next    = sat_reg;
        m2_next     = m2_reg;
        idx_next    = idx_reg;
        mcnt_next   = mcnt_reg;
        s30_next    = s30_reg;
        mag_next    = mag_reg;
        acc_next    = acc_reg;
        cord_start  = 1'b0;
        sq_start    = 1'b0;
        dv_start    = 1'b0;
        sq_a        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    zero_next = 1'b0;
                    sat_next  = 1'b0;
                    if (!kind)
                    begin
                        q_next      = '{load_w, load_x, load_y, load_z};
                        ovalid_next = 1'b1;
                    end
                    else
                    begin
                        m2_next    = '0;
                        idx_next   = '0;
                        state_next = S_MAG;
                    end
                end
            end
            S_MAG:
            begin
                // one square per cycle through a shared multiplier
                sq_a    = 32'(ax_sel) * 32'(ax_sel);
                m2_next = m2_reg + 34'(unsigned'(sq_a));
                if (idx_reg == 2'd2)
                begin
                    idx_next   = '0;
                    state_next = S_CORD;
                end
                else
                    idx_next = idx_reg + 2'd1;
            end
            S_CORD:
            begin
                if (m2_reg == '0)
                begin
                    zero_next   = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cord_start = 1'b1;
                    sq_start   = 1'b1;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (cord_done)
                begin
                    s30_next = sin30;
                    r_next.w = 16'(cosr);
                end
                if (sq_done)
                begin
                    mag_next   = root;
                    state_next = S_SINM;
                end
            end
            S_SINM:
            begin
                dv_start   = 1'b1;
                state_next = S_DIVS;
            end
            S_DIVS:
            begin
                if (dv_done)
                begin
                    unique case (idx_reg)
                        2'd0:    r_next.x = num_s[63] ? -16'(rq) : 16'(rq);
                        2'd1:    r_next.y = num_s[63] ? -16'(rq) : 16'(rq);
                        default: r_next.z = num_s[63] ? -16'(rq) : 16'(rq);
                    endcase
                    state_next = S_DIVW;
                end
            end
            S_DIVW:
            begin
                if (idx_reg == 2'd2)
                begin
                    mcnt_next  = '0;
                    acc_next   = '0;
                    state_next = S_MUL;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = S_SINM;
                end
            end
            S_MUL:
            begin
                mcnt_next = mcnt_reg + 4'd1;
                if (mcnt_reg == 4'd15)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                state_next = S_OUT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // accumulate the registered product, keep each finished part aside
        // so later terms still see the old orientation
        if (prod_en_reg)
        begin
            acc_next = acc_sum;
            if (plast_reg)
            begin
                logic signed [15:0] cl;
                cl = 16'(sh);
                if (sh > AccW'(32767))
                begin
                    cl       = 16'sh7fff;
                    sat_next = 1'b1;
                end
                else if (sh < -AccW'(32768))
                begin
                    cl       = -16'sh8000;
                    sat_next = 1'b1;
                end
                unique case (pidx_reg)
                    2'd0:    n_next.w = cl;
                    2'd1:    n_next.x = cl;
                    2'd2:    n_next.y = cl;
                    default: q_next   = '{n_reg.w, n_reg.x, n_reg.y, cl};
                endcase
                if (pidx_reg == 2'd3)
                begin
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
                acc_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ovalid_reg  <= 1'b0;
            q_reg       <= '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
            prod_en_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ovalid_reg  <= ovalid_next;
            q_reg       <= q_next;
            prod_en_reg <= (state_reg == S_MUL);
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg   <= r_next;
        n_reg   <= n_next;
        zero_reg <= zero_next;
        sat_reg <= sat_next;
        m2_reg  <= m2_next;
        idx_reg <= idx_next;
        mcnt_reg <= mcnt_next;
        s30_reg <= s30_next;
        mag_reg <= mag_next;
        acc_reg <= acc_next;
        if (in_acc)
        begin
            ax_reg  <= axis_x;
            ay_reg  <= axis_y;
            az_reg  <= axis_z;
            ang_reg <= angle;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_w     = q_reg.w;
    assign out_x     = q_reg.x;
    assign out_y     = q_reg.y;
    assign out_z     = q_reg.z;
    assign zero_axis = zero_reg;
    assign saturated = sat_reg;

endmodule

// File: sv/qor_checker.sv
// ------------------------------------------------------------------
// qor_checker
// port-level checks on the orientation rotator
// ------------------------------------------------------------------
`timescale 1ns / 1ps
`include "quaternion_orientation_rotator_assert.svh"

module qor_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [15:0] out_w,
    input  logic        zero_axis,
    input  logic        saturated
);

    `QOR_ASSERT_IMP(a_flags_excl, clk, rst_n, out_valid, !(zero_axis && saturated))
    `QOR_ASSERT_IMP(a_busy_when_out, clk, rst_n, out_valid, in_stall)
    `QOR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_w))
    `QOR_ASSERT_NEXT(a_no_early_out, clk, rst_n, !out_valid && !(in_valid && !in_stall) && in_stall == 1'b0, !out_valid)

endmodule

bind quaternion_orientation_rotator qor_checker u_qor_checker (.clk, .rst_n, .in_valid,
    .in_stall, .out_valid, .out_stall, .out_w, .zero_axis, .saturated);

// File: tb/tb_quaternion_orientation_rotator.sv
// ------------------------------------------------------------------
// tb_quaternion_orientation_rotator
// drives load and rotate words into the orientation rotator, predicts
// each new orientation with a bit-exact cordic, square root and
// hamilton product model, and compares every output word in order
// ------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_quaternion_orientation_rotator;

    import qor_pkg::*;

    localparam bit KindLoad   = 1'b0;
    localparam bit KindRotate = 1'b1;
    localparam int NumRandom  = 700;
    localparam longint CycleLimit = 2000000;

    localparam longint Gain   = 64'sd652032874;
    localparam longint HalfPi = 64'sd1686629713;
    localparam longint Pi     = 64'sd3373259426;
    localparam longint TwoPi  = 64'sd6746518852;

    typedef struct {
        bit    kind;
        comp_t ax, ay, az, ang;
        comp_t lw, lx, ly, lz;
    } cmd_t;

    typedef struct {
        comp_t w, x, y, z;
        bit    zero_ax;
        bit    sat;
    } orient_t;

    typedef struct {
        cmd_t    cmd;
        bit      known;
        orient_t res;
    } row_t;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_stall;
    logic  kind;
    logic signed [15:0] axis_x, axis_y, axis_z, angle;
    logic signed [15:0] load_w, load_x, load_y, load_z;
    logic  out_valid;
    logic  out_stall;
    logic signed [15:0] out_w, out_x, out_y, out_z;
    logic  zero_axis;
    logic  saturated;

    longint  orient_q[4];
    orient_t expected_orients[$];
    int      errors;
    longint  cycle;
    bit      hold_off;
    bit      calm;

    quaternion_orientation_rotator dut
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
        .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z), .angle(angle),
        .load_w(load_w), .load_x(load_x), .load_y(load_y), .load_z(load_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_w(out_w), .out_x(out_x), .out_y(out_y), .out_z(out_z),
        .zero_axis(zero_axis), .saturated(saturated)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint div_round(longint num, longint d);
        if (num >= 0)
            return (num + d / 2) / d;
        return -((-num + d / 2) / d);
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint clip(longint v, ref bit sat);
        if (v > 32767)
        begin
            sat = 1'b1;
            return 32767;
        end
        if (v < -32768)
        begin
            sat = 1'b1;
            return -32768;
        end
        return v;
    endfunction

    // applies one word to the held orientation and returns the new one
    function automatic orient_t apply_word(cmd_t c);
        orient_t o;
        longint ax, ay, az, m2, zz, cx, cy, dx, dy, mag, den;
        longint r[4];
        longint p[4];
        longint sum[4];
        bit neg;
        bit sat;
        o.zero_ax = 1'b0;
        o.sat = 1'b0;
        if (c.kind == KindLoad)
        begin
            orient_q[0] = c.lw;
            orient_q[1] = c.lx;
            orient_q[2] = c.ly;
            orient_q[3] = c.lz;
        end
        else
        begin
            ax = c.ax;
            ay = c.ay;
            az = c.az;
            m2 = ax * ax + ay * ay + az * az;
            if (m2 == 0)
                o.zero_ax = 1'b1;
            else
            begin
                zz = (longint'(c.ang) * (64'sd1 << 16)) % TwoPi;
                neg = 1'b0;
                if (zz > Pi) zz -= TwoPi;
                if (zz < -Pi) zz += TwoPi;
                if (zz > HalfPi)
                begin
                    zz -= Pi;
                    neg = 1'b1;
                end
                else if (zz < -HalfPi)
                begin
                    zz += Pi;
                    neg = 1'b1;
                end
                cx = Gain;
                cy = 0;
                for (int i = 0; i < CordicSteps; i++)
                begin
                    dx = floor_shift(cy, i);
                    dy = floor_shift(cx, i);
                    if (zz >= 0)
                    begin
                        cx -= dx;
                        cy += dy;
                        zz -= longint'(atan_entry(5'(i)));
                    end
                    else
                    begin
                        cx += dx;
                        cy -= dy;
                        zz += longint'(atan_entry(5'(i)));
                    end
                end
                if (neg)
                begin
                    cx = -cx;
                    cy = -cy;
                end
                mag = int_sqrt(longint'(m2) << 16);
                den = mag * (64'sd1 << 16);
                r[0] = div_round(cx, 64'sd1 << 16);
                r[1] = div_round(ax * cy * 256, den);
                r[2] = div_round(ay * cy * 256, den);
                r[3] = div_round(az * cy * 256, den);
                p = orient_q;
                sum[0] = p[0]*r[0] - p[1]*r[1] - p[2]*r[2] - p[3]*r[3];
                sum[1] = p[0]*r[1] + p[1]*r[0] + p[2]*r[3] - p[3]*r[2];
                sum[2] = p[0]*r[2] + p[2]*r[0] + p[3]*r[1] - p[1]*r[3];
                sum[3] = p[0]*r[3] + p[3]*r[0] + p[1]*r[2] - p[2]*r[1];
                sat = 1'b0;
                for (int k = 0; k < 4; k++)
                    orient_q[k] = clip(floor_shift(sum[k] + 8192, FracBits), sat);
                o.sat = sat;
            end
        end
        o.w = 16'(orient_q[0]);
        o.x = 16'(orient_q[1]);
        o.y = 16'(orient_q[2]);
        o.z = 16'(orient_q[3]);
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // output side: check every accepted word against the oldest prediction
    always @(posedge clk)
    begin
        orient_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_orients.size() == 0)
            begin
                $display("unexpected output word at %0t", $realtime);
                errors++;
            end
            else
            begin
                e = expected_orients.pop_front();
                if (out_w !== e.w) report_mismatch("out_w", out_w, e.w);
                if (out_x !== e.x) report_mismatch("out_x", out_x, e.x);
                if (out_y !== e.y) report_mismatch("out_y", out_y, e.y);
                if (out_z !== e.z) report_mismatch("out_z", out_z, e.z);
                if (zero_axis !== e.zero_ax) report_mismatch("zero_axis", zero_axis, e.zero_ax);
                if (saturated !== e.sat) report_mismatch("saturated", saturated, e.sat);
            end
        end
    end

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= !calm && ($urandom_range(99) < 15);
    end

    always @(posedge clk)
    begin
        cycle++;
        if (cycle > CycleLimit)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // valid stays high after acceptance only when the next word follows at once
    task automatic send_word(cmd_t c);
        orient_t e;
        while (!calm && $urandom_range(99) < 15)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        kind <= c.kind;
        axis_x <= c.ax;
        axis_y <= c.ay;
        axis_z <= c.az;
        angle <= c.ang;
        load_w <= c.lw;
        load_x <= c.lx;
        load_y <= c.ly;
        load_z <= c.lz;
        do
            @(posedge clk);
        while (in_stall);
        e = apply_word(c);
        expected_orients.push_back(e);
        @(negedge clk);
    endtask

    function automatic cmd_t make_cmd(bit k, comp_t ax, comp_t ay, comp_t az, comp_t ang,
                                      comp_t lw, comp_t lx, comp_t ly, comp_t lz);
        cmd_t c;
        c.kind = k;
        c.ax = ax; c.ay = ay; c.az = az; c.ang = ang;
        c.lw = lw; c.lx = lx; c.ly = ly; c.lz = lz;
        return c;
    endfunction

    function automatic comp_t rnd16();
        case ($urandom_range(5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'(int'($urandom_range(0, 32768)) - 16384);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic orient_t fixed(comp_t w, comp_t x, comp_t y, comp_t z, bit za);
        orient_t o;
        o.w = w; o.x = x; o.y = y; o.z = z; o.zero_ax = za; o.sat = 1'b0;
        return o;
    endfunction

    initial
    begin
        row_t   rows[$];
        row_t   rw;
        cmd_t   c;
        int     hold_cnt;
        errors = 0;
        cycle = 0;
        hold_off = 1'b0;
        calm = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        kind = KindLoad;
        {axis_x, axis_y, axis_z, angle} = '0;
        {load_w, load_x, load_y, load_z} = '0;
        orient_q[0] = 16384;
        orient_q[1] = 0;
        orient_q[2] = 0;
        orient_q[3] = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table: known rows are read straight off the definition
        rw.known = 1;
        rw.cmd = make_cmd(KindRotate, 0, 0, 0, 16'sh7fff, 0, 0, 0, 0);
        rw.res = fixed(16384, 0, 0, 0, 1); rows.push_back(rw);
        rw.cmd = make_cmd(KindLoad, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                          16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
        rw.res = fixed(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 0); rows.push_back(rw);
        rw.cmd = make_cmd(KindRotate, 0, 0, 0, 16'sh8000, 1, 2, 3, 4);
        rw.res = fixed(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 1); rows.push_back(rw);
        rw.known = 0;
        rw.cmd = make_cmd(KindRotate, 16384, 0, 0, 12868, 0, 0, 0, 0); rows.push_back(rw);
        rw.cmd = make_cmd(KindLoad, 0, 0, 0, 0, 16384, 0, 0, 0); rows.push_back(rw);
        rw.cmd = make_cmd(KindRotate, 16384, 0, 0, 12868, 0, 0, 0, 0); rows.push_back(rw);
        rw.cmd = make_cmd(KindRotate, 0, 16384, 0, 25736, 0, 0, 0, 0); rows.push_back(rw);
        rw.cmd = make_cmd(KindRotate, 0, 0, 16384, -25736, 0, 0, 0, 0); rows.push_back(rw);
        rw.cmd = make_cmd(KindRotate, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0, 0, 0);
        rows.push_back(rw);
        rw.cmd = make_cmd(KindRotate, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0, 0, 0, 0);
        rows.push_back(rw);
        rw.cmd = make_cmd(KindRotate, 1, 0, 0, 0, 0, 0, 0, 0); rows.push_back(rw);
        rw.cmd = make_cmd(KindRotate, 0, 0, -1, 25736, 0, 0, 0, 0); rows.push_back(rw);
        rw.cmd = make_cmd(KindLoad, 0, 0, 0, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        rows.push_back(rw);
        rw.cmd = make_cmd(KindRotate, 16384, 16384, 0, 6434, 0, 0, 0, 0); rows.push_back(rw);
        rw.cmd = make_cmd(KindLoad, 0, 0, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        rows.push_back(rw);
        rw.cmd = make_cmd(KindRotate, 0, 16'sh8000, 16'sh7fff, 16'sh8000, 0, 0, 0, 0);
        rows.push_back(rw);

        foreach (rows[i])
        begin
            send_word(rows[i].cmd);
            if (rows[i].known)
            begin
                if (expected_orients[$].w !== rows[i].res.w
                    || expected_orients[$].x !== rows[i].res.x
                    || expected_orients[$].zero_ax !== rows[i].res.zero_ax)
                    report_mismatch("directed row", i, i);
                expected_orients[$] = rows[i].res;
            end
        end

        for (int n = 0; n < NumRandom; n++)
        begin
            calm = (n >= 200 && n < 300);
            if (n == 400)
            begin
                // long receiver hold-off while words keep coming
                fork
                    begin
                        hold_off = 1'b1;
                        hold_cnt = 0;
                        while (hold_cnt < 600)
                        begin
                            @(posedge clk);
                            hold_cnt++;
                        end
                        hold_off = 1'b0;
                    end
                join_none
            end
            if (n == 500)
            begin
                in_valid <= 1'b0;
                while (expected_orients.size() != 0)
                    @(negedge clk);
            end
            if ($urandom_range(99) < 25)
                c = make_cmd(KindLoad, rnd16(), rnd16(), rnd16(), rnd16(),
                             rnd16(), rnd16(), rnd16(), rnd16());
            else if ($urandom_range(99) < 5)
                c = make_cmd(KindRotate, 0, 0, 0, rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
            else
                c = make_cmd(KindRotate, rnd16(), rnd16(), rnd16(), rnd16(),
                             rnd16(), rnd16(), rnd16(), rnd16());
            send_word(c);
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (expected_orients.size() != 0)
            @(negedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
